### hdl/llgtr_pkg.sv
`default_nettype none

package llgtr_pkg;

    // pipeline depth, input beat to result register
    localparam int NSTG = 11;

    localparam int MAG_W   = 32;
    localparam int FIELD_W = 32;
    localparam int DAMP_W  = 16;
    localparam int GYRO_W  = 32;
    localparam int RATE_W  = 48;
    localparam int ACC_W   = 65;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] CFG_GYRO_RATIO  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DAMPED_MODE = 1'd1;

    localparam logic [GYRO_W-1:0] GYRO_RESET = 32'h0100_0000;

    localparam logic signed [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};
    localparam logic signed [RATE_W-1:0] RATE_MIN = {1'b1, {(RATE_W-1){1'b0}}};

    typedef logic [NSTG-1:0] stage_en_t;

endpackage

`default_nettype wire

### hdl/llgtr_front.sv
`default_nettype none

module llgtr_front
    import llgtr_pkg::*;
(
    input  wire logic                      aclk,
    input  wire stage_en_t                 en,
    input  wire logic signed [MAG_W-1:0]   mag_in   [3],
    input  wire logic signed [FIELD_W-1:0] field_in [3],
    input  wire logic        [DAMP_W-1:0]  damping_in,
    output logic signed [MAG_W-1:0]        mag_out   [3],
    output logic signed [FIELD_W-1:0]      field_out [3],
    output logic        [DAMP_W-1:0]       damping_out,
    output logic signed [ACC_W-1:0]        cross_out [3],
    output logic signed [ACC_W-1:0]        perp_out  [3],
    output logic signed [ACC_W-1:0]        dot_out   [3]
);

    logic signed [63:0]        pbc_reg [3];
    logic signed [63:0]        pcb_reg [3];
    logic signed [63:0]        sq_reg  [3];
    logic signed [63:0]        dt_reg  [3];
    logic signed [MAG_W-1:0]   m1_reg  [3];
    logic signed [FIELD_W-1:0] h1_reg  [3];
    logic        [DAMP_W-1:0]  a1_reg;

    logic signed [ACC_W-1:0]   cross_reg [3];
    logic signed [ACC_W-1:0]   perp_reg  [3];
    logic signed [ACC_W-1:0]   dot_reg   [3];
    logic signed [MAG_W-1:0]   m2_reg    [3];
    logic signed [FIELD_W-1:0] h2_reg    [3];
    logic        [DAMP_W-1:0]  a2_reg;

    for (genvar i = 0; i < 3; i++) begin : g_ax
        localparam int NB = (i + 1) % 3;
        localparam int NC = (i + 2) % 3;

        // per-axis products: cross terms, squares, dot terms; each square and dot term feeds the other two axes
        always_ff @(posedge aclk) begin
            if (en[0]) begin
                pbc_reg[i] <= mag_in[NB] * field_in[NC];
                pcb_reg[i] <= mag_in[NC] * field_in[NB];
                sq_reg[i]  <= mag_in[i] * mag_in[i];
                dt_reg[i]  <= mag_in[i] * field_in[i];
                m1_reg[i]  <= mag_in[i];
                h1_reg[i]  <= field_in[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en[1]) begin
                cross_reg[i] <= ACC_W'(pbc_reg[i]) - ACC_W'(pcb_reg[i]);
                perp_reg[i]  <= ACC_W'(sq_reg[NB]) + ACC_W'(sq_reg[NC]);
                dot_reg[i]   <= ACC_W'(dt_reg[NB]) + ACC_W'(dt_reg[NC]);
                m2_reg[i]    <= m1_reg[i];
                h2_reg[i]    <= h1_reg[i];
            end
        end

        assign mag_out[i]   = m2_reg[i];
        assign field_out[i] = h2_reg[i];
        assign cross_out[i] = cross_reg[i];
        assign perp_out[i]  = perp_reg[i];
        assign dot_out[i]   = dot_reg[i];
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            a1_reg <= damping_in;
        end
        if (en[1]) begin
            a2_reg <= a1_reg;
        end
    end

    assign damping_out = a2_reg;

endmodule

`default_nettype wire

### hdl/llgtr_axis.sv
`default_nettype none

module llgtr_axis
    import llgtr_pkg::*;
(
    input  wire logic                      aclk,
    input  wire stage_en_t                 en,
    input  wire logic                      damped_mode,
    input  wire logic        [GYRO_W-1:0]  gyro_ratio,
    input  wire logic signed [MAG_W-1:0]   mag_in,
    input  wire logic signed [FIELD_W-1:0] field_in,
    input  wire logic signed [ACC_W-1:0]   cross_in,
    input  wire logic signed [ACC_W-1:0]   perp_in,
    input  wire logic signed [ACC_W-1:0]   dot_in,
    input  wire logic        [DAMP_W-1:0]  damping_in,
    output logic signed [RATE_W-1:0]       rate_out,
    output logic                           clip_out
);

    // split operands for the 32 x 65 products
    logic signed [32:0] perp_lo, perp_hi, dot_lo, dot_hi;

    logic signed [64:0]       hl_reg, hh_reg, ml_reg, mh_reg;
    logic signed [ACC_W-1:0]  c3_reg;
    logic        [DAMP_W-1:0] a3_reg;

    logic signed [65:0]       dhi_reg, dlo_reg;
    logic signed [ACC_W-1:0]  c4_reg;
    logic        [DAMP_W-1:0] a4_reg;

    logic signed [97:0]       brk_reg;
    logic signed [65:0]       tq_reg;
    logic        [DAMP_W-1:0] a5_reg;

    logic signed [16:0] alpha_s;
    logic signed [33:0] brk_hi;
    logic        [47:0] q0_reg, q1_reg;
    logic signed [50:0] q2_reg;
    logic signed [65:0] tq6_reg;

    logic signed [114:0] q20;
    logic signed [80:0]  q1s;
    logic signed [115:0] ad_reg;
    logic signed [65:0]  tq7_reg;

    logic signed [111:0] tq_sh;
    logic signed [115:0] total_reg;

    logic signed [32:0] gam_s;
    logic signed [19:0] tot_hi;
    logic        [63:0] g0_reg, g1_reg, g2_reg;
    logic signed [52:0] g3_reg;

    logic [93:0]        low_sum;
    logic [35:0]        ahi_reg;
    logic signed [56:0] bhi_reg;
    logic [1:0]         cy_reg;

    logic signed [57:0] q_sum;
    logic               fits;

    logic signed [RATE_W-1:0] rate_reg;
    logic                     clip_reg;

    assign perp_lo = $signed({1'b0, perp_in[31:0]});
    assign perp_hi = perp_in[64:32];
    assign dot_lo  = $signed({1'b0, dot_in[31:0]});
    assign dot_hi  = dot_in[64:32];

    // H_a * perp and m_a * dot as partial products
    always_ff @(posedge aclk) begin
        if (en[2]) begin
            hl_reg <= field_in * perp_lo;
            hh_reg <= field_in * perp_hi;
            ml_reg <= mag_in * dot_lo;
            mh_reg <= mag_in * dot_hi;
            c3_reg <= cross_in;
            a3_reg <= damping_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            dhi_reg <= 66'(hh_reg) - 66'(mh_reg);
            dlo_reg <= 66'(hl_reg) - 66'(ml_reg);
            c4_reg  <= c3_reg;
            a4_reg  <= a3_reg;
        end
    end

    // damping bracket, 76 fraction bits
    always_ff @(posedge aclk) begin
        if (en[4]) begin
            brk_reg <= $signed({dhi_reg, 32'h0}) + 98'(dlo_reg);
            tq_reg  <= 66'sd0 - 66'(c4_reg);
            a5_reg  <= a4_reg;
        end
    end

    assign alpha_s = $signed({1'b0, a5_reg});
    assign brk_hi  = brk_reg[97:64];

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            q0_reg  <= a5_reg * brk_reg[31:0];
            q1_reg  <= a5_reg * brk_reg[63:32];
            q2_reg  <= alpha_s * brk_hi;
            tq6_reg <= tq_reg;
        end
    end

    assign q20 = {q2_reg, 16'h0, q0_reg};
    assign q1s = $signed({1'b0, q1_reg, 32'h0});

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            ad_reg  <= 116'(q20) + 116'(q1s);
            tq7_reg <= tq6_reg;
        end
    end

    // precession term moved to 92 fraction bits
    assign tq_sh = {tq7_reg, 46'h0};

    always_ff @(posedge aclk) begin
        if (en[7]) begin
            if (damped_mode) begin
                total_reg <= ad_reg + 116'(tq_sh);
            end else begin
                total_reg <= 116'(tq_sh);
            end
        end
    end

    assign gam_s  = $signed({1'b0, gyro_ratio});
    assign tot_hi = total_reg[115:96];

    always_ff @(posedge aclk) begin
        if (en[8]) begin
            g0_reg <= gyro_ratio * total_reg[31:0];
            g1_reg <= gyro_ratio * total_reg[63:32];
            g2_reg <= gyro_ratio * total_reg[95:64];
            g3_reg <= gam_s * tot_hi;
        end
    end

    // carry out of the discarded 92 bits, rounding half included
    assign low_sum = 94'({g2_reg[27:0], g0_reg}) + 94'({g1_reg[59:0], 32'h0})
                   + (94'd1 << 91);

    always_ff @(posedge aclk) begin
        if (en[9]) begin
            ahi_reg <= g2_reg[63:28];
            bhi_reg <= {g3_reg, g1_reg[63:60]};
            cy_reg  <= low_sum[93:92];
        end
    end

    assign q_sum = 58'($signed({1'b0, ahi_reg})) + 58'(bhi_reg)
                 + 58'($signed({1'b0, cy_reg}));
    assign fits  = (q_sum[57:RATE_W-1] == {(58-RATE_W+1){1'b0}})
                || (q_sum[57:RATE_W-1] == {(58-RATE_W+1){1'b1}});

    always_ff @(posedge aclk) begin
        if (en[10]) begin
            if (fits) begin
                rate_reg <= q_sum[RATE_W-1:0];
            end else if (q_sum[57]) begin
                rate_reg <= RATE_MIN;
            end else begin
                rate_reg <= RATE_MAX;
            end
            clip_reg <= !fits;
        end
    end

    assign rate_out = rate_reg;
    assign clip_out = clip_reg;

endmodule

`default_nettype wire

### hdl/llg_torque_rate.sv
// llg_torque_rate: per-site dm/dt of the LLG equation, fixed point
// throughput: one beat per cycle; each stage holds one item and a stall
//   freezes only the stages that are full up to the stalled output
// reset: clears every stage valid bit, gyro_ratio to 1.0, damped_mode to 1
`default_nettype none

module llg_torque_rate
    import llgtr_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,

    input  wire logic                      cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]     cfg_wdata,

    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic signed [MAG_W-1:0]   s_mag_x,
    input  wire logic signed [MAG_W-1:0]   s_mag_y,
    input  wire logic signed [MAG_W-1:0]   s_mag_z,
    input  wire logic signed [FIELD_W-1:0] s_field_x,
    input  wire logic signed [FIELD_W-1:0] s_field_y,
    input  wire logic signed [FIELD_W-1:0] s_field_z,
    input  wire logic        [DAMP_W-1:0]  s_damping,

    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic signed [RATE_W-1:0]       m_rate_x,
    output logic signed [RATE_W-1:0]       m_rate_y,
    output logic signed [RATE_W-1:0]       m_rate_z,
    output logic                           m_clipped
);

    logic [GYRO_W-1:0] gyro_reg;
    logic              mode_reg;

    stage_en_t v_reg, v_next;
    stage_en_t rdy;

    logic signed [MAG_W-1:0]   mag_arr   [3];
    logic signed [FIELD_W-1:0] field_arr [3];

    logic signed [MAG_W-1:0]   mag_f   [3];
    logic signed [FIELD_W-1:0] field_f [3];
    logic        [DAMP_W-1:0]  damp_f;
    logic signed [ACC_W-1:0]   cross_f [3];
    logic signed [ACC_W-1:0]   perp_f  [3];
    logic signed [ACC_W-1:0]   dot_f   [3];

    logic signed [RATE_W-1:0] rate_ax [3];
    logic [2:0]               clip_ax;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gyro_reg <= GYRO_RESET;
            mode_reg <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_GYRO_RATIO:  gyro_reg <= cfg_wdata[GYRO_W-1:0];
                CFG_DAMPED_MODE: mode_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // a stage takes new data when it is empty or its successor moves
    assign rdy[NSTG-1] = ~v_reg[NSTG-1] | m_ready;
    for (genvar k = 0; k < NSTG - 1; k++) begin : g_rdy
        assign rdy[k] = ~v_reg[k] | rdy[k+1];
    end

    assign v_next[0] = rdy[0] ? s_valid : v_reg[0];
    for (genvar k = 1; k < NSTG; k++) begin : g_vld
        assign v_next[k] = rdy[k] ? v_reg[k-1] : v_reg[k];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign s_ready = rdy[0];
    assign m_valid = v_reg[NSTG-1];

    assign mag_arr[0]   = s_mag_x;
    assign mag_arr[1]   = s_mag_y;
    assign mag_arr[2]   = s_mag_z;
    assign field_arr[0] = s_field_x;
    assign field_arr[1] = s_field_y;
    assign field_arr[2] = s_field_z;

    llgtr_front u_front (
        .aclk        (aclk),
        .en          (rdy),
        .mag_in      (mag_arr),
        .field_in    (field_arr),
        .damping_in  (s_damping),
        .mag_out     (mag_f),
        .field_out   (field_f),
        .damping_out (damp_f),
        .cross_out   (cross_f),
        .perp_out    (perp_f),
        .dot_out     (dot_f)
    );

    for (genvar i = 0; i < 3; i++) begin : g_axis
        llgtr_axis u_axis (
            .aclk        (aclk),
            .en          (rdy),
            .damped_mode (mode_reg),
            .gyro_ratio  (gyro_reg),
            .mag_in      (mag_f[i]),
            .field_in    (field_f[i]),
            .cross_in    (cross_f[i]),
            .perp_in     (perp_f[i]),
            .dot_in      (dot_f[i]),
            .damping_in  (damp_f),
            .rate_out    (rate_ax[i]),
            .clip_out    (clip_ax[i])
        );
    end

    assign m_rate_x  = rate_ax[0];
    assign m_rate_y  = rate_ax[1];
    assign m_rate_z  = rate_ax[2];
    assign m_clipped = |clip_ax;

endmodule

`default_nettype wire
